>>> rtl/core/mrgq_pkg.sv
`timescale 1ns / 1ps
package mrgq_pkg;
	localparam int LIMB_BITS = 31;
	localparam int LIMB_COUNT = 13;
	localparam int WIDE_COUNT = 2 * LIMB_COUNT;
	localparam int IDX_W = 5;
	localparam int OUT_IDX_W = 4;
	localparam int ACC_W = 36;

	typedef enum logic [1:0] {
		OP_LOAD_T = 2'd0,
		OP_LOAD_M = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	function automatic logic [LIMB_BITS-1:0] prime_limb(input logic [3:0] j);
		case (j)
			4'd0: prime_limb = 31'h7FFFAAAB;
			4'd1: prime_limb = 31'h73FDFFFF;
			4'd2: prime_limb = 31'h454FFFFE;
			4'd3: prime_limb = 31'h755FFFF5;
			4'd4: prime_limb = 31'h6B0F6241;
			4'd5: prime_limb = 31'h661A541E;
			4'd6: prime_limb = 31'h6144AFD9;
			4'd7: prime_limb = 31'h3BA5C279;
			4'd8: prime_limb = 31'h4BACD764;
			4'd9: prime_limb = 31'h374F6C86;
			4'd10: prime_limb = 31'h7F9A692C;
			4'd11: prime_limb = 31'h088F51CB;
			4'd12: prime_limb = 31'h000001A0;
			default: prime_limb = '0;
		endcase
	endfunction
endpackage

>>> rtl/core/mrgq_if.sv
`timescale 1ns / 1ps
interface mrgq_in_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [4:0] limb_index;
	logic [30:0] limb_value;
	modport source (output valid, operation, limb_index, limb_value, input ready);
	modport sink (input valid, operation, limb_index, limb_value, output ready);
endinterface

interface mrgq_out_if;
	logic valid;
	logic ready;
	logic [3:0] result_index;
	logic [30:0] result_limb;
	logic last;
	modport source (output valid, result_index, result_limb, last, input ready);
	modport sink (input valid, result_index, result_limb, last, output ready);
endinterface

>>> rtl/core/mrgq_mem.sv
`timescale 1ns / 1ps
module mrgq_mem #(
	parameter int DEPTH = 26,
	parameter int AW = 5,
	parameter int DW = 31
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/montgomery_reduce_given_quotient.sv
`timescale 1ns / 1ps
// Loads are written to the stores as they are accepted. For a compute item,
// the product m*p is formed one limb product at a time (169 products in the
// first 25 of 26 columns, each in three steps: the m-store read, the 31x31
// multiplier register and the accumulate; each column then writes its sum to
// the sum store), then t is added limb by limb through the sum store (a read
// step and a write step per limb, 26 limbs), and the 13 upper limbs are sent
// one by one while the sink is ready. The single multiplier and the
// one-read-port stores keep the work serial. No item is taken during compute.
module montgomery_reduce_given_quotient #(
	parameter int LIMB_BITS = mrgq_pkg::LIMB_BITS,
	parameter int LIMB_COUNT = mrgq_pkg::LIMB_COUNT
) (
	input logic clk,
	input logic arst_n,
	mrgq_in_if.sink in_ch,
	mrgq_out_if.source out_ch
);
	import mrgq_pkg::*;
	localparam int WC = 2 * LIMB_COUNT;

	typedef enum logic [2:0] {S_IDLE, S_MRD, S_MUL, S_ACC, S_COL, S_ADD, S_EMIT} st_t;
	st_t state_q;

	logic [4:0] col_q, i_q, rk_q;
	logic [ACC_W-1:0] hi_q;
	logic [LIMB_BITS-1:0] lo_q;
	logic [2*LIMB_BITS-1:0] prod_q;
	logic [LIMB_BITS:0] c_q;
	logic ph_q;

	logic t_we, m_we, s_we;
	logic [4:0] t_wa, s_wa, t_ra, s_ra;
	logic [3:0] m_wa, m_ra;
	logic [LIMB_BITS-1:0] t_wd, s_wd, t_rd, m_rd, s_rd;

	mrgq_mem #(.DEPTH(WC), .AW(5), .DW(LIMB_BITS)) u_t (.clk(clk), .we(t_we),
		.waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
	mrgq_mem #(.DEPTH(LIMB_COUNT), .AW(4), .DW(LIMB_BITS)) u_m (.clk(clk), .we(m_we),
		.waddr(m_wa), .wdata(t_wd), .raddr(m_ra), .rdata(m_rd));
	mrgq_mem #(.DEPTH(WC), .AW(5), .DW(LIMB_BITS)) u_s (.clk(clk), .we(s_we),
		.waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	logic acc_fire;
	assign acc_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	logic [3:0] j_w;
	assign j_w = 4'(col_q - i_q);
	logic [LIMB_BITS:0] lsum;
	assign lsum = {1'b0, lo_q} + {1'b0, prod_q[LIMB_BITS-1:0]};
	logic [LIMB_BITS+1:0] asum;
	assign asum = {2'b0, t_rd} + {2'b0, s_rd} + {1'b0, c_q};

	assign t_we = acc_fire && in_ch.operation == OP_LOAD_T && in_ch.limb_index < 5'(WC);
	assign m_we = acc_fire && in_ch.operation == OP_LOAD_M
		&& in_ch.limb_index < 5'(LIMB_COUNT);
	assign t_wa = in_ch.limb_index;
	assign m_wa = in_ch.limb_index[3:0];
	assign t_wd = in_ch.limb_value;
	assign m_ra = i_q[3:0];
	assign t_ra = rk_q;
	assign s_ra = (state_q == S_EMIT) ? rk_q + 5'(LIMB_COUNT) : rk_q;

	always_comb begin
		s_we = 1'b0;
		s_wa = col_q;
		s_wd = lo_q;
		if (state_q == S_COL) begin
			s_we = 1'b1;
		end else if (state_q == S_ADD && ph_q) begin
			s_we = 1'b1;
			s_wa = rk_q;
			s_wd = asum[LIMB_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q <= '0; i_q <= '0; rk_q <= '0; hi_q <= '0; lo_q <= '0;
			c_q <= '0; ph_q <= 1'b0; prod_q <= '0;
			out_ch.valid <= 1'b0;
			out_ch.result_index <= '0;
			out_ch.result_limb <= '0;
			out_ch.last <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc_fire && in_ch.operation == OP_COMPUTE) begin
						col_q <= '0; lo_q <= '0; hi_q <= '0; i_q <= '0;
						state_q <= S_MRD;
					end
				end
				S_MRD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= m_rd * prime_limb(j_w);
					state_q <= S_ACC;
				end
				S_ACC: begin
					lo_q <= lsum[LIMB_BITS-1:0];
					hi_q <= hi_q + ACC_W'(prod_q[2*LIMB_BITS-1:LIMB_BITS])
						+ ACC_W'(lsum[LIMB_BITS]);
					if (i_q == col_q || i_q == 5'(LIMB_COUNT - 1)) begin
						state_q <= S_COL;
					end else begin
						i_q <= i_q + 5'd1;
						state_q <= S_MRD;
					end
				end
				S_COL: begin
					lo_q <= hi_q[LIMB_BITS-1:0];
					hi_q <= hi_q >> LIMB_BITS;
					if (col_q == 5'(WC - 1)) begin
						rk_q <= '0; c_q <= '0; ph_q <= 1'b0;
						state_q <= S_ADD;
					end else begin
						col_q <= col_q + 5'd1;
						i_q <= (col_q + 5'd1 < 5'(LIMB_COUNT)) ? 5'd0
							: col_q + 5'd1 - 5'(LIMB_COUNT - 1);
						state_q <= (col_q + 5'd1 == 5'(WC - 1)) ? S_COL : S_MRD;
					end
				end
				S_ADD: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						c_q <= {{(LIMB_BITS-1){1'b0}}, asum[LIMB_BITS+1:LIMB_BITS]};
						if (rk_q == 5'(WC - 1)) begin
							rk_q <= '0; ph_q <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							rk_q <= rk_q + 5'd1;
						end
					end
				end
				S_EMIT: begin
					if (!ph_q) begin
						if (!out_ch.valid || out_ch.ready) begin
							out_ch.valid <= 1'b0;
							ph_q <= 1'b1;
						end
					end else begin
						out_ch.valid <= 1'b1;
						out_ch.result_index <= rk_q[3:0];
						out_ch.result_limb <= s_rd;
						out_ch.last <= (rk_q == 5'(LIMB_COUNT - 1));
						ph_q <= 1'b0;
						if (rk_q == 5'(LIMB_COUNT - 1)) state_q <= S_IDLE;
						else rk_q <= rk_q + 5'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q != S_EMIT && out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
		end
	end
endmodule
